### rtl/core/olfbd_pkg.sv
`default_nettype none

package olfbd_pkg;

    // Default list capacity in entries.
    localparam int CAPACITY_DEF = 16;

    // Field widths.
    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [STATUS_W-1:0]      t_status;

    // Operation codes carried by an input item.
    localparam t_op OP_FRONT  = 2'd0;
    localparam t_op OP_BACK   = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    // Status codes carried by a result.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_EMPTY    = 2'd3;

endpackage

`default_nettype wire

### rtl/core/ordered_list_front_back_delete.sv
// Insert back, any insert into a full list and read out of an empty list leave busy low;
// their result shows in the cycle after the accepting edge.
// Insert front and delete keep busy high while the sequencer walks the list, and the final
// result shows as it returns to idle. Read out alternates a RAM read step and an output step,
// one entry per output step. A new item is taken in the cycle the final result shows.
// Results are single-cycle strobes the receiver cannot stall; reset (synchronous, active low)
// empties the list and leaves cell contents as they are.
`default_nettype none

module ordered_list_front_back_delete #(
    parameter int CAPACITY = olfbd_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  olfbd_pkg::t_op       i_op,
    input  olfbd_pkg::t_word     i_value,
    output logic                 o_strobe,
    output olfbd_pkg::t_status   o_status,
    output olfbd_pkg::t_word     o_entry,
    output logic                 o_last
);
    import olfbd_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SH_RD  = 9'b000000010,
        S_SH_WR  = 9'b000000100,
        S_SR_RD  = 9'b000001000,
        S_SR_CMP = 9'b000010000,
        S_DL_RD  = 9'b000100000,
        S_DL_WR  = 9'b001000000,
        S_RO_RD  = 9'b010000000,
        S_RO_OUT = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    t_word           r_value, n_value;
    logic            r_strobe, n_strobe;
    t_status         r_status, n_status;
    t_word           r_entry, n_entry;
    logic            r_last, n_last;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_word           mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_word           mem_rdata;

    logic [CW-1:0]   idx_inc;
    logic [CW-1:0]   idx_dec;
    logic            list_full;

    olfbd_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared index stepper and fill check.
    assign idx_inc   = CW'(r_idx + 1'b1);
    assign idx_dec   = CW'(r_idx - 1'b1);
    assign list_full = (r_count == CW'(CAPACITY));

    // Sequencer: one RAM access per cycle, the shared compare in the search step.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_value   = r_value;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_entry   = r_entry;
        n_last    = r_last;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_value = i_value;
                    n_idx   = '0;
                    unique case (i_op) inside
                        OP_FRONT, OP_BACK: begin
                            if (list_full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                                n_entry  = '0;
                                n_last   = 1'b1;
                            end else if (i_op == OP_BACK) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_value;
                                n_count   = CW'(r_count + 1'b1);
                                n_strobe  = 1'b1;
                                n_status  = ST_OK;
                                n_entry   = '0;
                                n_last    = 1'b1;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_SH_RD;
                            end
                        end
                        OP_DELETE: begin
                            n_state = S_SR_RD;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                                n_entry  = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_state = S_RO_RD;
                            end
                        end
                    endcase
                end
            end

            // Insert front: move entries up one place from the back, then write the front.
            S_SH_RD: begin
                if (r_idx == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_value;
                    n_count   = CW'(r_count + 1'b1);
                    n_strobe  = 1'b1;
                    n_status  = ST_OK;
                    n_entry   = '0;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    mem_raddr = idx_dec[AW-1:0];
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = idx_dec;
                n_state   = S_SH_RD;
            end

            // Delete: search from the front for the first matching entry.
            S_SR_RD: begin
                if (r_idx == r_count) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_entry  = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    mem_raddr = r_idx[AW-1:0];
                    n_state   = S_SR_CMP;
                end
            end
            S_SR_CMP: begin
                if (mem_rdata == r_value) begin
                    n_state = S_DL_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SR_RD;
                end
            end

            // Delete: close the gap by moving later entries down one place.
            S_DL_RD: begin
                if (idx_inc == r_count) begin
                    n_count  = CW'(r_count - 1'b1);
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_entry  = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    mem_raddr = idx_inc[AW-1:0];
                    n_state   = S_DL_WR;
                end
            end
            S_DL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = idx_inc;
                n_state   = S_DL_RD;
            end

            // Read out: one entry per RAM read, front to back.
            S_RO_RD: begin
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_RO_OUT;
            end
            S_RO_OUT: begin
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_entry  = mem_rdata;
                n_last   = (idx_inc == r_count);
                n_idx    = idx_inc;
                n_state  = (idx_inc == r_count) ? S_IDLE : S_RO_RD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_last   <= n_last;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_entry  = r_entry;
    assign o_last   = r_last;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    // The final result of an item is shown only once the sequencer is back at rest.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("final result while sequencer busy");

    // An insert at the back with room is answered in the next cycle with ok.
    a_back_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_BACK && !list_full)
            |=> (o_strobe && o_last && o_status == ST_OK))
        else $error("insert back not acknowledged");

    // A read out of an empty list gives the empty status at once.
    a_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_READ && r_count == '0)
            |=> (o_strobe && o_last && o_status == ST_EMPTY))
        else $error("empty read out not reported");

endmodule

`default_nettype wire

### rtl/core/olfbd_ram.sv
`default_nettype none

module olfbd_ram #(
    parameter int DEPTH = olfbd_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(olfbd_pkg::CAPACITY_DEF)
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  olfbd_pkg::t_word    i_wdata,
    input  wire [AW-1:0]        i_raddr,
    output olfbd_pkg::t_word    o_rdata
);
    import olfbd_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
